FILE: rtl/aesctr_pkg.sv
// Shared constants, types and AES round functions for the CTR keystream block.
package aesctr_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int RK_DEPTH    = ROUND_COUNT + 1;
  localparam int RK_AW       = $clog2(RK_DEPTH);
  localparam int EXP_WORDS   = 4 * RK_DEPTH;
  localparam int EXP_CW      = $clog2(EXP_WORDS + 1);
  localparam int CFG_IW      = 3;

  localparam logic [CFG_IW-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_NONCE = 3'd4;

  typedef struct packed {
    logic             we_lo;
    logic             we_hi;
    logic [RK_AW-1:0] addr;
    logic [63:0]      data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the state sits at bits [8k+7:8k]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(s[8*(r + 4*((c + r) % 4)) +: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

FILE: rtl/aes256_ctr_keystream.sv
// AES-256 counter-mode keystream generator, top level.
// Each nonzero request word yields one 128-bit keystream block from an iterative
// round unit (whitening plus 14 rounds), one round key per cycle from two 15-entry
// round key RAMs; a new request is taken in the cycle the previous block moves to
// the output register, so a new block starts as the last one leaves the round unit.
// After reset and after every register write the key schedule is rebuilt, one word
// per cycle, with in_tready low; the block counter is cleared.
// A request of zero bytes is taken and produces no word.
module aes256_ctr_keystream
  import aesctr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // bytes_wanted[4:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [135:0]      out_tdata,  // keystream_low, keystream_high, bytes_valid
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam logic [RK_AW-1:0] LAST = RK_AW'(ROUND_COUNT);

  logic [255:0]     key_r;
  logic [63:0]      nonce_r, ctr_r;
  logic             busy_r, out_tvalid_r;
  logic [RK_AW-1:0] rnd_r, raddr;
  logic [127:0]     st_r, ss, st_nxt, rk;
  logic [63:0]      rk_lo, rk_hi;
  logic [4:0]       want, want_r, bv_r;
  logic [127:0]     ks_r;
  logic             cfg_hit, kx_busy, fin, acc, start;
  rk_wr_t           wr;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_NONCE);

  aesctr_keyexp u_kx (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cfg_hit),
    .key  (key_r),
    .busy (kx_busy),
    .wr   (wr)
  );

  aesctr_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_rk_lo (
    .clk(clk), .we(wr.we_lo), .waddr(wr.addr), .wdata(wr.data),
    .raddr(raddr), .rdata(rk_lo)
  );

  aesctr_ram #(.WIDTH(64), .DEPTH(RK_DEPTH)) u_rk_hi (
    .clk(clk), .we(wr.we_hi), .waddr(wr.addr), .wdata(wr.data),
    .raddr(raddr), .rdata(rk_hi)
  );

  assign rk = {rk_hi, rk_lo};

  assign fin       = busy_r && (rnd_r == LAST) && (!out_tvalid_r || out_tready);
  assign in_tready = !kx_busy && (!busy_r || fin);
  assign acc       = in_tvalid && in_tready;
  assign want      = in_tdata[4:0];
  assign start     = acc && (want != 5'd0);

  always_comb begin
    if (busy_r && rnd_r != LAST) begin
      raddr = rnd_r + 1'b1;
    end else if (busy_r && !fin) begin
      raddr = LAST;
    end else begin
      raddr = '0;
    end
  end

  assign ss = sub_shift(st_r);
  always_comb begin
    if (rnd_r == '0) begin
      st_nxt = st_r ^ rk;
    end else if (rnd_r == LAST) begin
      st_nxt = ss ^ rk;
    end else begin
      st_nxt = mix_columns(ss) ^ rk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0:  key_r[63:0]    <= cfg_data;
        CFG_KEY1:  key_r[127:64]  <= cfg_data;
        CFG_KEY2:  key_r[191:128] <= cfg_data;
        CFG_KEY3:  key_r[255:192] <= cfg_data;
        CFG_NONCE: nonce_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      rnd_r        <= '0;
      out_tvalid_r <= 1'b0;
      ctr_r        <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (busy_r && rnd_r != LAST) begin
        rnd_r <= rnd_r + 1'b1;
      end
      if (fin) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_hit) begin
        ctr_r <= '0;
      end else if (start) begin
        ctr_r <= ctr_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r   <= {ctr_r, nonce_r};
      want_r <= (want > 5'd16) ? 5'd16 : want;
    end else if (busy_r && rnd_r != LAST) begin
      st_r <= st_nxt;
    end
    if (fin) begin
      ks_r <= st_nxt;
      bv_r <= want_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, bv_r, ks_r};

  a_no_req_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
    kx_busy |-> !in_tready) else $error("request taken during key expansion");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rnd_r <= LAST)) else $error("round index out of range");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && rnd_r == '0)) else $error("block did not start");
  a_cfg_expand: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (kx_busy && ctr_r == '0)) else $error("write did not restart schedule");

endmodule

FILE: rtl/aesctr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aesctr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aesctr_keyexp.sv
// AES-256 key expansion, one 32-bit word per cycle, written into the round key RAMs.
module aesctr_keyexp
  import aesctr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  output logic         busy,
  output rk_wr_t       wr
);

  logic [EXP_CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]       win_r [8];
  logic [31:0]       w, t;
  logic [7:0]        rc;
  logic [4:0]        half;

  assign busy = (cnt_r != EXP_CW'(EXP_WORDS));
  assign rc   = 8'h01 << (cnt_r[5:3] - 3'd1);

  always_comb begin
    t = win_r[7];
    if (cnt_r[2:0] == 3'd0) begin
      t = {sbox(t[7:0]), sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]) ^ rc};
    end else if (cnt_r[2:0] == 3'd4) begin
      t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    end
    if (cnt_r < EXP_CW'(8)) begin
      w = key[32*cnt_r[2:0] +: 32];
    end else begin
      w = win_r[0] ^ t;
    end
  end

  assign half     = cnt_r[5:1];
  assign wr.we_lo = busy && cnt_r[0] && !half[0];
  assign wr.we_hi = busy && cnt_r[0] && half[0];
  assign wr.addr  = half[4:1];
  assign wr.data  = {w, win_r[7]};

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !start) begin
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[7] <= w;
    end
  end

endmodule
